// ===== src/osc_pkg.sv =====
// ----------------------------------------------------------------------------
// osc_pkg
// Shared types and constants for the outline segment to cubic path converter.
// ----------------------------------------------------------------------------
package osc_pkg;

	// field widths
	localparam int PT_W      = 16;
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 3;
	localparam int COORD_W   = 48;
	localparam int QUOT_W    = COORD_W - 1;
	localparam int SUM_W     = COORD_W + 2;

	// divide-by-three split: a coordinate is cut into a signed high half and an
	// unsigned low half, each divided by a reciprocal multiply
	localparam int SPLIT        = COORD_W / 2;
	localparam int PQ_W         = SPLIT - 1;
	localparam int PROD_W       = 2 * CFG_W;
	localparam int RECIP3_SHIFT = CFG_W + 1;
	localparam logic [CFG_W-1:0] RECIP3      = 32'hAAAA_AAAB;
	localparam logic [SPLIT-1:0] THIRD_SPLIT = SPLIT'(((64'd1 << SPLIT) - 64'd1) / 64'd3);
	localparam logic [SPLIT:0]   HI_BIAS     = (SPLIT + 1)'(3) << (SPLIT - 2);
	localparam logic [PQ_W-1:0]  HI_BIAS_Q   = PQ_W'(1) << (SPLIT - 2);

	// segment kinds
	localparam logic [2:0] MODE_MOVE  = 3'd0;
	localparam logic [2:0] MODE_LINE  = 3'd1;
	localparam logic [2:0] MODE_QUAD  = 3'd2;
	localparam logic [2:0] MODE_CUBIC = 3'd3;
	localparam logic [2:0] MODE_END   = 3'd4;

	// path element codes
	localparam logic [1:0] CODE_MOVETO  = 2'd0;
	localparam logic [1:0] CODE_LINETO  = 2'd1;
	localparam logic [1:0] CODE_CURVETO = 2'd2;
	localparam logic [1:0] CODE_END     = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_COEF_XX  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_XY  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_YX  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_YY  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 3'd5;

	typedef struct packed {
		logic [2:0]              mode;
		logic signed [PT_W-1:0]  ctrl1_x;
		logic signed [PT_W-1:0]  ctrl1_y;
		logic signed [PT_W-1:0]  ctrl2_x;
		logic signed [PT_W-1:0]  ctrl2_y;
		logic signed [PT_W-1:0]  end_x;
		logic signed [PT_W-1:0]  end_y;
	} seg_t;

	typedef struct packed {
		logic [1:0]                path_code;
		logic signed [COORD_W-1:0] out_c1_x;
		logic signed [COORD_W-1:0] out_c1_y;
		logic signed [COORD_W-1:0] out_c2_x;
		logic signed [COORD_W-1:0] out_c2_y;
		logic signed [COORD_W-1:0] out_end_x;
		logic signed [COORD_W-1:0] out_end_y;
	} path_t;

	typedef struct packed {
		logic signed [CFG_W-1:0] coef_xx;
		logic signed [CFG_W-1:0] coef_xy;
		logic signed [CFG_W-1:0] coef_yx;
		logic signed [CFG_W-1:0] coef_yy;
		logic signed [CFG_W-1:0] offset_x;
		logic signed [CFG_W-1:0] offset_y;
	} xform_cfg_t;

	// load enables of the pipeline stages
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
		logic s7;
	} stage_en_t;

	// coordinate with its floor quotient and remainder by three, and x - q
	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [QUOT_W-1:0]  q;
		logic [1:0]                r;
		logic signed [COORD_W-1:0] a;
	} third_t;

endpackage

// ===== src/outline_segment_to_cubic_path_top.sv =====
// ----------------------------------------------------------------------------
// outline_segment_to_cubic_path_top
// Converts outline segments to moveto, lineto and curveto path elements.
// ----------------------------------------------------------------------------
// Takes one segment per clock while seg_stall is low and presents its path
// element from the result register at the end of the pipeline. The rate is
// set by the final stage, where the previous end point is compared and used
// for the quadratic's first control point; transform products, sums and the
// divide by three run in the stages before it. Stages advance into bubbles,
// so a stalled result holds only the items queued behind it. Repeated moves
// and lines and segment modes five to seven produce no element.
module outline_segment_to_cubic_path_top #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 seg_valid,
	output logic                                 seg_stall,
	input  osc_pkg::seg_t                        seg,
	output logic                                 path_valid,
	input  logic                                 path_stall,
	output osc_pkg::path_t                       path,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [osc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [osc_pkg::CFG_W-1:0]            cfg_data
);
	import osc_pkg::*;

	localparam logic signed [CFG_W-1:0] UNITY = CFG_W'(1) << FRAC_BITS;

	xform_cfg_t                cfg_q;
	stage_en_t                 en;
	seg_t                      seg_s1;
	logic                      v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic [2:0]                mode_s2, mode_s3, mode_s4, mode_s5, mode_s6;
	logic signed [COORD_W-1:0] c1x_s3, c1y_s3, c2x_s3, c2y_s3, ex_s3, ey_s3;
	logic signed [COORD_W-1:0] c2x_s4, c2y_s4, c2x_s5, c2y_s5, c2x_s6, c2y_s6;
	third_t                    cx_s6, cy_s6, ex_s6, ey_s6;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.coef_xx  <= UNITY;
			cfg_q.coef_xy  <= '0;
			cfg_q.coef_yx  <= '0;
			cfg_q.coef_yy  <= UNITY;
			cfg_q.offset_x <= '0;
			cfg_q.offset_y <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_COEF_XX:  cfg_q.coef_xx  <= cfg_data;
				REG_COEF_XY:  cfg_q.coef_xy  <= cfg_data;
				REG_COEF_YX:  cfg_q.coef_yx  <= cfg_data;
				REG_COEF_YY:  cfg_q.coef_yy  <= cfg_data;
				REG_OFFSET_X: cfg_q.offset_x <= cfg_data;
				REG_OFFSET_Y: cfg_q.offset_y <= cfg_data;
				default: ;
			endcase
		end
	end

	// advance a stage when it is empty or the next one advances
	assign en.s7     = !path_valid || !path_stall;
	assign en.s6     = !v_s6 || en.s7;
	assign en.s5     = !v_s5 || en.s6;
	assign en.s4     = !v_s4 || en.s5;
	assign en.s3     = !v_s3 || en.s4;
	assign en.s2     = !v_s2 || en.s3;
	assign en.s1     = !v_s1 || en.s2;
	assign seg_stall = !en.s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en.s1) v_s1 <= seg_valid;
			if (en.s2) v_s2 <= v_s1;
			if (en.s3) v_s3 <= v_s2;
			if (en.s4) v_s4 <= v_s3;
			if (en.s5) v_s5 <= v_s4;
			if (en.s6) v_s6 <= v_s5;
		end
	end

	// input register and segment kind pipeline
	always_ff @(posedge clk) begin
		if (en.s1) seg_s1 <= seg;
		if (en.s2) mode_s2 <= seg_s1.mode;
		if (en.s3) mode_s3 <= mode_s2;
		if (en.s4) mode_s4 <= mode_s3;
		if (en.s5) mode_s5 <= mode_s4;
		if (en.s6) mode_s6 <= mode_s5;
	end

	// transform the three points
	osc_xform u_xf_c1 (
		.clk     (clk),
		.en      (en),
		.cfg     (cfg_q),
		.pt_x    (seg_s1.ctrl1_x),
		.pt_y    (seg_s1.ctrl1_y),
		.xf_x_s3 (c1x_s3),
		.xf_y_s3 (c1y_s3)
	);

	osc_xform u_xf_c2 (
		.clk     (clk),
		.en      (en),
		.cfg     (cfg_q),
		.pt_x    (seg_s1.ctrl2_x),
		.pt_y    (seg_s1.ctrl2_y),
		.xf_x_s3 (c2x_s3),
		.xf_y_s3 (c2y_s3)
	);

	osc_xform u_xf_end (
		.clk     (clk),
		.en      (en),
		.cfg     (cfg_q),
		.pt_x    (seg_s1.end_x),
		.pt_y    (seg_s1.end_y),
		.xf_x_s3 (ex_s3),
		.xf_y_s3 (ey_s3)
	);

	// divide the quadratic control and end point by three
	osc_div3 u_dv_cx (.clk(clk), .en(en), .x_s3(c1x_s3), .d_s6(cx_s6));
	osc_div3 u_dv_cy (.clk(clk), .en(en), .x_s3(c1y_s3), .d_s6(cy_s6));
	osc_div3 u_dv_ex (.clk(clk), .en(en), .x_s3(ex_s3),  .d_s6(ex_s6));
	osc_div3 u_dv_ey (.clk(clk), .en(en), .x_s3(ey_s3),  .d_s6(ey_s6));

	// carry the cubic's second control point alongside
	always_ff @(posedge clk) begin
		if (en.s4) begin
			c2x_s4 <= c2x_s3;
			c2y_s4 <= c2y_s3;
		end
		if (en.s5) begin
			c2x_s5 <= c2x_s4;
			c2y_s5 <= c2y_s4;
		end
		if (en.s6) begin
			c2x_s6 <= c2x_s5;
			c2y_s6 <= c2y_s5;
		end
	end

	osc_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.v_s6       (v_s6),
		.mode_s6    (mode_s6),
		.c_x        (cx_s6),
		.c_y        (cy_s6),
		.e_x        (ex_s6),
		.e_y        (ey_s6),
		.d_x        (c2x_s6),
		.d_y        (c2y_s6),
		.path_valid (path_valid),
		.path       (path)
	);

	// a stalled request means every stage is full behind a stalled result
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		seg_stall |-> (v_s1 && v_s6 && path_valid && path_stall))
		else $error("segment stalled while the pipeline has room");

	// an accepted request enters the first stage
	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(seg_valid && !seg_stall) |=> v_s1)
		else $error("accepted segment lost at the input register");

	// no result appears without an item in the last stage
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		(!v_s6 && (!path_valid || !path_stall)) |=> !path_valid)
		else $error("path element appeared from an empty stage");

endmodule

// ===== src/osc_xform.sv =====
// ----------------------------------------------------------------------------
// osc_xform
// Affine transform of one point: products in stage 2, sum with offset and
// saturation to the 48-bit coordinate range in stage 3.
// ----------------------------------------------------------------------------
module osc_xform (
	input  logic                               clk,
	input  osc_pkg::stage_en_t                 en,
	input  osc_pkg::xform_cfg_t                cfg,
	input  logic signed [osc_pkg::PT_W-1:0]    pt_x,
	input  logic signed [osc_pkg::PT_W-1:0]    pt_y,
	output logic signed [osc_pkg::COORD_W-1:0] xf_x_s3,
	output logic signed [osc_pkg::COORD_W-1:0] xf_y_s3
);
	import osc_pkg::*;

	logic signed [COORD_W-1:0] xx_s2, yx_s2, xy_s2, yy_s2;
	logic signed [CFG_W-1:0]   offset_x_s2, offset_y_s2;
	logic signed [SUM_W-1:0]   sum_x, sum_y;

	function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
		logic signed [COORD_W-1:0] r;
		if (v[SUM_W-1:COORD_W-1] == {(SUM_W - COORD_W + 1){v[SUM_W-1]}}) begin
			r = v[COORD_W-1:0];
		end else if (v[SUM_W-1]) begin
			r = {1'b1, {(COORD_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(COORD_W-1){1'b1}}};
		end
		return r;
	endfunction

	// form the four weighted terms
	always_ff @(posedge clk) begin
		if (en.s2) begin
			xx_s2       <= COORD_W'(pt_x) * COORD_W'(cfg.coef_xx);
			yx_s2       <= COORD_W'(pt_y) * COORD_W'(cfg.coef_yx);
			xy_s2       <= COORD_W'(pt_x) * COORD_W'(cfg.coef_xy);
			yy_s2       <= COORD_W'(pt_y) * COORD_W'(cfg.coef_yy);
			offset_x_s2 <= cfg.offset_x;
			offset_y_s2 <= cfg.offset_y;
		end
	end

	// add terms and translation
	assign sum_x = SUM_W'(xx_s2) + SUM_W'(yx_s2) + SUM_W'(offset_x_s2);
	assign sum_y = SUM_W'(xy_s2) + SUM_W'(yy_s2) + SUM_W'(offset_y_s2);

	// clamp to the coordinate range
	always_ff @(posedge clk) begin
		if (en.s3) begin
			xf_x_s3 <= sat_coord(sum_x);
			xf_y_s3 <= sat_coord(sum_y);
		end
	end

endmodule

// ===== src/osc_div3.sv =====
// ----------------------------------------------------------------------------
// osc_div3
// Floor division of one signed coordinate by three over stages 4 to 6.
// The high and low halves are divided by reciprocal multiplies, the partial
// quotients and remainders are merged, and x - q is formed for the control
// point arithmetic downstream.
// ----------------------------------------------------------------------------
module osc_div3 (
	input  logic                               clk,
	input  osc_pkg::stage_en_t                 en,
	input  logic signed [osc_pkg::COORD_W-1:0] x_s3,
	output osc_pkg::third_t                    d_s6
);
	import osc_pkg::*;

	logic [SPLIT:0]            hb;
	logic [SPLIT-1:0]          lo;
	logic [PROD_W-1:0]         hp, lp;
	logic [PQ_W-1:0]           qh_s4, ql_s4;
	logic [1:0]                hlo_s4, llo_s4;
	logic signed [COORD_W-1:0] x_s4, x_s5;
	logic [1:0]                rh, rl;
	logic signed [PQ_W-1:0]    qhs;
	logic [SPLIT-1:0]          rh_part;
	logic [2:0]                rsum;
	logic                      wrap;
	logic signed [QUOT_W-1:0]  q, q_s5;
	logic [1:0]                r, r_s5;

	// bias the signed high half positive, then multiply by the reciprocal
	assign hb = {x_s3[COORD_W-1], x_s3[COORD_W-1:SPLIT]} + HI_BIAS;
	assign lo = x_s3[SPLIT-1:0];
	assign hp = PROD_W'(hb) * PROD_W'(RECIP3);
	assign lp = PROD_W'(lo) * PROD_W'(RECIP3);

	always_ff @(posedge clk) begin
		if (en.s4) begin
			qh_s4  <= hp[RECIP3_SHIFT +: PQ_W];
			ql_s4  <= lp[RECIP3_SHIFT +: PQ_W];
			hlo_s4 <= hb[1:0];
			llo_s4 <= lo[1:0];
			x_s4   <= x_s3;
		end
	end

	// recover half remainders and merge the halves; 2^SPLIT is one more
	// than a multiple of three
	assign rh  = 2'(hlo_s4 - 2'(qh_s4[1:0] * 2'd3));
	assign rl  = 2'(llo_s4 - 2'(ql_s4[1:0] * 2'd3));
	assign qhs = qh_s4 - HI_BIAS_Q;

	always_comb begin
		case (rh)
			2'd1:    rh_part = THIRD_SPLIT;
			2'd2:    rh_part = THIRD_SPLIT << 1;
			default: rh_part = '0;
		endcase
	end

	assign rsum = 3'(rh) + 3'(rl);
	assign wrap = (rsum >= 3'd3);
	assign q    = {qhs, {SPLIT{1'b0}}} + QUOT_W'(ql_s4) + QUOT_W'(rh_part) + QUOT_W'(wrap);
	assign r    = wrap ? 2'(rsum - 3'd3) : rsum[1:0];

	always_ff @(posedge clk) begin
		if (en.s5) begin
			q_s5 <= q;
			r_s5 <= r;
			x_s5 <= x_s4;
		end
	end

	// hold quotient, remainder and x - q
	always_ff @(posedge clk) begin
		if (en.s6) begin
			d_s6.x <= x_s5;
			d_s6.q <= q_s5;
			d_s6.r <= r_s5;
			d_s6.a <= x_s5 - COORD_W'(q_s5);
		end
	end

endmodule

// ===== src/osc_emit.sv =====
// ----------------------------------------------------------------------------
// osc_emit
// Final stage: holds the previous end point, drops repeated moves and lines,
// raises quadratics to cubics and loads the result register.
// ----------------------------------------------------------------------------
module osc_emit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  osc_pkg::stage_en_t                 en,
	input  logic                               v_s6,
	input  logic [2:0]                         mode_s6,
	input  osc_pkg::third_t                    c_x,
	input  osc_pkg::third_t                    c_y,
	input  osc_pkg::third_t                    e_x,
	input  osc_pkg::third_t                    e_y,
	input  logic signed [osc_pkg::COORD_W-1:0] d_x,
	input  logic signed [osc_pkg::COORD_W-1:0] d_y,
	output logic                               path_valid,
	output osc_pkg::path_t                     path
);
	import osc_pkg::*;

	logic signed [COORD_W-1:0] prev_x_q, prev_y_q;
	logic signed [QUOT_W-1:0]  prev_qx_q, prev_qy_q;
	logic [1:0]                prev_rx_q, prev_ry_q;
	logic                      have_prev_q;
	logic                      dup, emit, upd, clr;
	path_t                     res;

	// c - trunc((c - s)/3) and c + trunc((e - c)/3) both reduce to
	// (c - floor(c/3)) + floor(other/3) plus a one-step correction
	function automatic logic signed [COORD_W-1:0] ctl_pt(
		input logic signed [COORD_W-1:0] a,
		input logic signed [QUOT_W-1:0]  q,
		input logic                      inc,
		input logic                      dec
	);
		return a + COORD_W'(q) + COORD_W'(inc) - COORD_W'(dec);
	endfunction

	// decide the result of the item in stage 6
	always_comb begin
		res  = '0;
		emit = 1'b0;
		upd  = 1'b0;
		clr  = 1'b0;
		dup  = have_prev_q && (e_x.x == prev_x_q) && (e_y.x == prev_y_q);
		case (mode_s6)
			MODE_MOVE: begin
				emit              = !dup;
				upd               = !dup;
				res.path_code     = CODE_MOVETO;
				res.out_end_x     = e_x.x;
				res.out_end_y     = e_y.x;
			end
			MODE_LINE: begin
				emit              = !dup;
				upd               = !dup;
				res.path_code     = CODE_LINETO;
				res.out_end_x     = e_x.x;
				res.out_end_y     = e_y.x;
			end
			MODE_QUAD: begin
				emit              = 1'b1;
				upd               = 1'b1;
				res.path_code     = CODE_CURVETO;
				res.out_c1_x      = ctl_pt(c_x.a, prev_qx_q, c_x.r < prev_rx_q,
					(c_x.x < prev_x_q) && (c_x.r != prev_rx_q));
				res.out_c1_y      = ctl_pt(c_y.a, prev_qy_q, c_y.r < prev_ry_q,
					(c_y.x < prev_y_q) && (c_y.r != prev_ry_q));
				res.out_c2_x      = ctl_pt(c_x.a, e_x.q,
					(e_x.x < c_x.x) && (e_x.r != c_x.r), e_x.r < c_x.r);
				res.out_c2_y      = ctl_pt(c_y.a, e_y.q,
					(e_y.x < c_y.x) && (e_y.r != c_y.r), e_y.r < c_y.r);
				res.out_end_x     = e_x.x;
				res.out_end_y     = e_y.x;
			end
			MODE_CUBIC: begin
				emit              = 1'b1;
				upd               = 1'b1;
				res.path_code     = CODE_CURVETO;
				res.out_c1_x      = c_x.x;
				res.out_c1_y      = c_y.x;
				res.out_c2_x      = d_x;
				res.out_c2_y      = d_y;
				res.out_end_x     = e_x.x;
				res.out_end_y     = e_y.x;
			end
			MODE_END: begin
				emit              = 1'b1;
				clr               = 1'b1;
				res.path_code     = CODE_END;
			end
			default: ;
		endcase
	end

	// track the last emitted end point
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			prev_qx_q   <= '0;
			prev_qy_q   <= '0;
			prev_rx_q   <= '0;
			prev_ry_q   <= '0;
			have_prev_q <= 1'b0;
		end else if (en.s7 && v_s6) begin
			if (clr) begin
				prev_x_q    <= '0;
				prev_y_q    <= '0;
				prev_qx_q   <= '0;
				prev_qy_q   <= '0;
				prev_rx_q   <= '0;
				prev_ry_q   <= '0;
				have_prev_q <= 1'b0;
			end else if (upd) begin
				prev_x_q    <= e_x.x;
				prev_y_q    <= e_y.x;
				prev_qx_q   <= e_x.q;
				prev_qy_q   <= e_y.q;
				prev_rx_q   <= e_x.r;
				prev_ry_q   <= e_y.r;
				have_prev_q <= 1'b1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			path_valid <= 1'b0;
		end else if (en.s7) begin
			path_valid <= v_s6 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s7) begin
			path <= res;
		end
	end

endmodule
